@@ hdl/ssdbw_pkg.sv @@
// Shared types, codes and lookup functions for the seven-segment display bus writer.
// No dependencies; every other file in hdl/ imports this package.
package ssdbw_pkg;

  localparam int DIGIT_COUNT_DEFAULT = 4;

  // Request types.
  localparam logic [1:0] REQ_SHOW  = 2'd0;
  localparam logic [1:0] REQ_BLANK = 2'd1;
  localparam logic [1:0] REQ_POINT = 2'd2;

  // Bus symbol kinds.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  // Configuration register indexes.
  localparam logic [7:0] CFG_BRIGHTNESS   = 8'd0;
  localparam logic [7:0] CFG_SEGMENT_MODE = 8'd1;
  localparam logic [7:0] CFG_DISPLAY_ON   = 8'd2;
  localparam logic [7:0] CFG_MODE_ADDRESS = 8'd3;

  localparam logic [7:0] MODE_ADDRESS_RESET = 8'h48;
  localparam logic [7:0] POINT_BIT          = 8'h80;
  localparam logic [3:0] MAX_DIGIT_VALUE    = 4'd9;

  localparam logic [2:0] LAST_STEP = 3'd7;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] digit_pos;
    logic [3:0] digit_value;
    logic       dot_on;
  } in_item_t;

  typedef struct packed {
    logic [1:0] symbol_kind;
    logic [7:0] symbol_byte;
    logic       last_symbol;
  } out_item_t;

  // One display update waiting for the bus sequencer.
  typedef struct packed {
    logic [7:0] mode_addr;
    logic [7:0] cmd;
    logic [7:0] digit_addr;
    logic [7:0] segs;
  } job_t;

  function automatic logic [7:0] seg_code(input logic [3:0] value);
    logic [7:0] code;
    case (value)
      4'd0:    code = 8'h3f;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5b;
      4'd3:    code = 8'h4f;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6d;
      4'd6:    code = 8'h7d;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7f;
      4'd9:    code = 8'h6f;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] digit_address(input logic [1:0] pos);
    logic [7:0] addr;
    case (pos)
      2'd0:    addr = 8'h68;
      2'd1:    addr = 8'h6a;
      2'd2:    addr = 8'h6c;
      default: addr = 8'h6e;
    endcase
    return addr;
  endfunction

endpackage

@@ hdl/ssdbw_front.sv @@
// Front end: configuration registers, decimal-point flags and request classification.
// Depends on ssdbw_pkg; feeds completed jobs to ssdbw_queue.
module ssdbw_front #(
  parameter int DIGIT_COUNT = ssdbw_pkg::DIGIT_COUNT_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               accept,
  input  ssdbw_pkg::in_item_t in_item,
  output logic               job_valid,
  output ssdbw_pkg::job_t    job
);
  import ssdbw_pkg::*;

  logic [2:0]             bright_r,   bright_nxt;
  logic                   seg_mode_r, seg_mode_nxt;
  logic                   disp_on_r,  disp_on_nxt;
  logic [7:0]             mode_addr_r, mode_addr_nxt;
  logic [DIGIT_COUNT-1:0] flags_r,    flags_nxt;

  logic pos_ok;
  logic flag;
  logic show_ok;
  logic blank_ok;

  always_comb begin
    bright_nxt    = bright_r;
    seg_mode_nxt  = seg_mode_r;
    disp_on_nxt   = disp_on_r;
    mode_addr_nxt = mode_addr_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BRIGHTNESS:   bright_nxt    = cfg_data[2:0];
        CFG_SEGMENT_MODE: seg_mode_nxt  = cfg_data[0];
        CFG_DISPLAY_ON:   disp_on_nxt   = cfg_data[0];
        CFG_MODE_ADDRESS: mode_addr_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_ok = int'(in_item.digit_pos) < DIGIT_COUNT;
    flag   = 1'b0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (int'(in_item.digit_pos) == i) begin
        flag = flags_r[i];
      end
    end
    show_ok  = pos_ok && (in_item.req_type == REQ_SHOW) &&
               (in_item.digit_value <= MAX_DIGIT_VALUE);
    blank_ok = pos_ok && (in_item.req_type == REQ_BLANK);
  end

  always_comb begin
    flags_nxt = flags_r;
    if (accept && pos_ok && (in_item.req_type == REQ_POINT)) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (int'(in_item.digit_pos) == i) begin
          flags_nxt[i] = in_item.dot_on;
        end
      end
    end
  end

  // The command and segment bytes are fixed at acceptance. The user must change configuration
  // only while the block is idle (not enforced here), so that nothing queued sees a stale value.
  always_comb begin
    job_valid      = accept && (show_ok || blank_ok);
    job.mode_addr  = mode_addr_r;
    job.cmd        = {1'b0, bright_r, seg_mode_r, 2'b00, disp_on_r};
    job.digit_addr = digit_address(in_item.digit_pos);
    job.segs       = show_ok ? (seg_code(in_item.digit_value) | (flag ? POINT_BIT : 8'h00))
                             : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r    <= 3'd0;
      seg_mode_r  <= 1'b0;
      disp_on_r   <= 1'b1;
      mode_addr_r <= MODE_ADDRESS_RESET;
      flags_r     <= '0;
    end else begin
      bright_r    <= bright_nxt;
      seg_mode_r  <= seg_mode_nxt;
      disp_on_r   <= disp_on_nxt;
      mode_addr_r <= mode_addr_nxt;
      flags_r     <= flags_nxt;
    end
  end

endmodule

@@ hdl/ssdbw_queue.sv @@
// Two-entry job queue that decouples request classification from the bus sequencer.
// Depends on ssdbw_pkg for the job type.
module ssdbw_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ssdbw_pkg::job_t push_job,
  input  logic            pop,
  output ssdbw_pkg::job_t head,
  output logic            full,
  output logic            empty
);
  import ssdbw_pkg::*;

  job_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r,  count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ hdl/ssdbw_back.sv @@
// Bus sequencer: walks the queued job through its eight symbols into the output register.
// Depends on ssdbw_pkg; reads the head of ssdbw_queue.
module ssdbw_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  ssdbw_pkg::job_t      q_head,
  output logic                 q_pop,
  input  logic                 out_pop,
  output logic                 out_empty,
  output ssdbw_pkg::out_item_t out_item
);
  import ssdbw_pkg::*;

  logic [2:0] step_r,  step_nxt;
  logic       out_v_r, out_v_nxt;
  out_item_t  out_r;
  out_item_t  sym;
  logic       load;

  // A new symbol enters when the output register is free or is drained this cycle.
  assign load      = !q_empty && (!out_v_r || out_pop);
  assign q_pop     = load && (step_r == LAST_STEP);
  assign out_empty = !out_v_r;
  assign out_item  = out_r;

  always_comb begin
    sym.symbol_byte = 8'h00;
    sym.last_symbol = 1'b0;
    case (step_r)
      3'd0: sym.symbol_kind = KIND_START;
      3'd1: begin
        sym.symbol_kind = KIND_DATA;
        sym.symbol_byte = q_head.mode_addr;
      end
      3'd2: begin
        sym.symbol_kind = KIND_DATA;
        sym.symbol_byte = q_head.cmd;
      end
      3'd3: sym.symbol_kind = KIND_STOP;
      3'd4: sym.symbol_kind = KIND_START;
      3'd5: begin
        sym.symbol_kind = KIND_DATA;
        sym.symbol_byte = q_head.digit_addr;
      end
      3'd6: begin
        sym.symbol_kind = KIND_DATA;
        sym.symbol_byte = q_head.segs;
      end
      3'd7: begin
        sym.symbol_kind = KIND_STOP;
        sym.last_symbol = 1'b1;
      end
      default: sym.symbol_kind = KIND_STOP;
    endcase
  end

  always_comb begin
    step_nxt  = load ? step_r + 3'd1 : step_r;
    out_v_nxt = out_v_r;
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 3'd0;
      out_v_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      out_v_r <= out_v_nxt;
    end
  end

endmodule

@@ hdl/seven_segment_display_bus_writer.sv @@
// Top level of the seven-segment display bus writer: front end, job queue, bus sequencer.
// Depends on ssdbw_pkg, ssdbw_front, ssdbw_queue and ssdbw_back.
//
// Usage: requests arrive on the in_ queue port (push/full) and bus symbols leave on
// the out_ queue port (empty/pop). A show or blank request for a digit in range turns
// into eight symbols: start, mode address, command, stop, start, digit address,
// segment byte, stop, the last one flagged by last_symbol. A point request only
// updates that digit's stored decimal-point flag and yields nothing; rejected
// requests yield nothing either. Registers are written on the cfg_ port, which is
// always ready, and must only be written while no request is still in flight.
//
// With the sequencer idle, a request's job is written into the queue on its transfer in,
// and the sequencer then loads its first symbol into the output register. It loads one
// symbol per cycle from the queue head while the receiver keeps draining the output;
// point requests only set a flag and never enter the queue. A two-entry job queue lets a
// further request be accepted while symbols are still going out.
// When the receiver stalls, the current symbol holds in the output register, the
// sequencer waits, and full rises once the queue fills.
// Reset clears the point flags, loads register defaults and empties the queue.
module seven_segment_display_bus_writer #(
  parameter int DIGIT_COUNT = ssdbw_pkg::DIGIT_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  ssdbw_pkg::in_item_t  in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output ssdbw_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_index,
  input  logic [7:0]           cfg_data
);
  import ssdbw_pkg::*;

  logic job_valid;
  job_t job;
  job_t q_head;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic in_accept;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign in_accept = in_push && !in_full;

  ssdbw_front #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (in_accept),
    .in_item  (in_item),
    .job_valid(job_valid),
    .job      (job)
  );

  ssdbw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_valid),
    .push_job(job),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  ssdbw_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_item (out_item)
  );

  // The final symbol of a sequence is always a stop.
  a_last_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.last_symbol) |-> (out_item.symbol_kind == KIND_STOP))
    else $error("last symbol is not a stop");

  // Start and stop symbols carry a zero byte.
  a_framing_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_item.symbol_kind != KIND_DATA)) |-> (out_item.symbol_byte == 8'h00))
    else $error("framing symbol carries a nonzero byte");

  // A queued job reaches an empty output register on the next edge.
  a_no_idle_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && out_empty) |=> !out_empty)
    else $error("sequencer idled with work queued");

  // Only the sequencer drains the queue, and only on the closing stop.
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (!out_empty && out_item.last_symbol))
    else $error("queue drained without a closing stop");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for seven_segment_display_bus_writer.
// Predicts the bus symbols of every accepted request and checks them in order.
// Depends on ssdbw_pkg and the RTL under hdl/.
module tb;
  import ssdbw_pkg::*;

  localparam int DIGIT_COUNT    = 4;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LONG_HOLD      = 400;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [1:0] REQ_UNUSED       = 2'd3;
  localparam logic [7:0] CFG_UNUSED_INDEX = 8'd4;
  localparam logic [7:0] DIGIT_ADDR_BASE  = 8'h68;
  localparam logic [7:0] BLANK_SEGS       = 8'h00;
  // Segment patterns for 0 to 9, digit 0 in the low byte.
  localparam logic [79:0] SEG_LUT = {8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d,
                                     8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  seven_segment_display_bus_writer #(.DIGIT_COUNT(DIGIT_COUNT)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: a private copy of the registers and point flags.
  logic [2:0] mdl_bright;
  logic       mdl_seg_mode;
  logic       mdl_disp_on;
  logic [7:0] mdl_mode_addr;
  logic [3:0] mdl_points;

  in_item_t   req_pending[$];
  out_item_t  symbols_due[$];
  reg_write_t cfg_pending[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int symbols_checked = 0;
  int n_display = 0;
  int n_point = 0;
  int n_rejected = 0;
  int n_settings = 1;

  function automatic bit is_rejected(input in_item_t req);
    return (req.digit_pos >= DIGIT_COUNT) || (req.req_type == REQ_UNUSED) ||
           (req.req_type == REQ_SHOW && req.digit_value > MAX_DIGIT_VALUE);
  endfunction

  task automatic push_symbol(input logic [1:0] kind, input logic [7:0] sym_byte,
                             input logic last);
    out_item_t sym;
    sym.symbol_kind = kind;
    sym.symbol_byte = sym_byte;
    sym.last_symbol = last;
    symbols_due.push_back(sym);
  endtask

  task automatic predict_bus_symbols(input in_item_t req);
    logic [7:0] segs;
    logic [7:0] cmd;
    if (is_rejected(req)) begin
      n_rejected++;
    end else if (req.req_type == REQ_POINT) begin
      mdl_points[req.digit_pos] = req.dot_on;
      n_point++;
    end else begin
      n_display++;
      if (req.req_type == REQ_SHOW) begin
        segs = SEG_LUT[req.digit_value*8 +: 8];
        if (mdl_points[req.digit_pos]) segs = segs | POINT_BIT;
      end else begin
        segs = BLANK_SEGS;
      end
      cmd = {1'b0, mdl_bright, mdl_seg_mode, 2'b00, mdl_disp_on};
      push_symbol(KIND_START, 8'h00, 1'b0);
      push_symbol(KIND_DATA, mdl_mode_addr, 1'b0);
      push_symbol(KIND_DATA, cmd, 1'b0);
      push_symbol(KIND_STOP, 8'h00, 1'b0);
      push_symbol(KIND_START, 8'h00, 1'b0);
      push_symbol(KIND_DATA, DIGIT_ADDR_BASE + {5'd0, req.digit_pos, 1'b0}, 1'b0);
      push_symbol(KIND_DATA, segs, 1'b0);
      push_symbol(KIND_STOP, 8'h00, 1'b1);
    end
  endtask

  // Request driver: holds an offer until its transfer, then may idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      mdl_points = 4'd0;
    end else begin
      if (in_push && !in_full) begin
        predict_bus_symbols(in_item);
        void'(req_pending.pop_front());
      end
      if (in_push && in_full) begin
        in_push <= 1'b1;
      end else if (req_pending.size() > 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        in_push <= 1'b1;
        in_item <= req_pending[0];
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Register writer: applies each write to the predictor on its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      mdl_bright <= 3'd0;
      mdl_seg_mode <= 1'b0;
      mdl_disp_on <= 1'b1;
      mdl_mode_addr <= MODE_ADDRESS_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BRIGHTNESS:   mdl_bright <= cfg_data[2:0];
          CFG_SEGMENT_MODE: mdl_seg_mode <= cfg_data[0];
          CFG_DISPLAY_ON:   mdl_disp_on <= cfg_data[0];
          CFG_MODE_ADDRESS: mdl_mode_addr <= cfg_data;
          default: ;
        endcase
        void'(cfg_pending.pop_front());
      end
      if (cfg_valid && !cfg_ready) begin
        cfg_valid <= 1'b1;
      end else if (cfg_pending.size() > 0) begin
        cfg_valid <= 1'b1;
        cfg_index <= cfg_pending[0].index;
        cfg_data <= cfg_pending[0].data;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // Symbol monitor: checks each transfer out against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        symbols_checked++;
        if (symbols_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected symbol kind=%0d byte=%02h last=%0b",
                     out_item.symbol_kind, out_item.symbol_byte, out_item.last_symbol);
        end else if (symbols_due[0] !== out_item) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("expected kind=%0d byte=%02h last=%0b, got kind=%0d byte=%02h last=%0b",
                     symbols_due[0].symbol_kind, symbols_due[0].symbol_byte,
                     symbols_due[0].last_symbol, out_item.symbol_kind,
                     out_item.symbol_byte, out_item.last_symbol);
          void'(symbols_due.pop_front());
        end else begin
          void'(symbols_due.pop_front());
        end
      end
      if (hold_trigger != hold_seen) begin
        hold_seen <= hold_trigger;
        hold_left <= LONG_HOLD;
        out_pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic in_item_t make_req(input logic [1:0] kind, input logic [1:0] pos,
                                        input logic [3:0] val, input logic dot);
    in_item_t req;
    req.req_type = kind;
    req.digit_pos = pos;
    req.digit_value = val;
    req.dot_on = dot;
    return req;
  endfunction

  // Mostly well-formed requests, with some rejected ones mixed in.
  function automatic in_item_t random_request();
    int pick;
    logic [1:0] pos;
    logic dot;
    pick = $urandom_range(0, 99);
    pos = 2'($urandom_range(0, 3));
    dot = 1'($urandom_range(0, 1));
    if (pick < 50)
      return make_req(REQ_SHOW, pos, 4'($urandom_range(0, 9)), dot);
    else if (pick < 65)
      return make_req(REQ_BLANK, pos, 4'($urandom_range(0, 15)), dot);
    else if (pick < 85)
      return make_req(REQ_POINT, pos, 4'($urandom_range(0, 15)), dot);
    else if (pick < 93)
      return make_req(REQ_SHOW, pos, 4'($urandom_range(10, 15)), dot);
    else
      return make_req(REQ_UNUSED, pos, 4'($urandom_range(0, 15)), dot);
  endfunction

  task automatic wait_idle();
    while (req_pending.size() != 0 || in_push || symbols_due.size() != 0 ||
           cfg_pending.size() != 0 || cfg_valid || hold_left != 0)
      @(negedge clk);
    // Point and rejected requests leave no symbols, so let them settle too.
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic queue_write(input logic [7:0] index, input logic [7:0] data);
    reg_write_t wr;
    wr.index = index;
    wr.data = data;
    cfg_pending.push_back(wr);
  endtask

  task automatic run_phase(input logic [7:0] bright, input logic [7:0] seg_mode,
                           input logic [7:0] disp_on, input logic [7:0] mode_addr,
                           input int send_pct, input int recv_pct, input int n_items,
                           input bit long_hold, input bit odd_write);
    int counted;
    in_item_t req;
    wait_idle();
    queue_write(CFG_BRIGHTNESS, bright);
    queue_write(CFG_SEGMENT_MODE, seg_mode);
    queue_write(CFG_DISPLAY_ON, disp_on);
    queue_write(CFG_MODE_ADDRESS, mode_addr);
    if (odd_write) queue_write(CFG_UNUSED_INDEX, 8'($urandom_range(0, 255)));
    while (cfg_pending.size() != 0 || cfg_valid) @(negedge clk);
    n_settings++;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    // The receiver holds off while the sender keeps offering requests.
    if (long_hold) hold_trigger++;
    counted = 0;
    while (counted < n_items) begin
      req = random_request();
      req_pending.push_back(req);
      counted++;
    end
  endtask

  initial begin
    int d;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests under the reset register values.
    for (d = 0; d <= 9; d++)
      req_pending.push_back(make_req(REQ_SHOW, 2'(d % 4), 4'(d), 1'(d % 2)));
    req_pending.push_back(make_req(REQ_POINT, 2'd1, 4'd0, 1'b1));
    req_pending.push_back(make_req(REQ_SHOW, 2'd1, 4'd8, 1'b0));
    req_pending.push_back(make_req(REQ_POINT, 2'd2, 4'd15, 1'b1));
    req_pending.push_back(make_req(REQ_BLANK, 2'd2, 4'd15, 1'b1));
    req_pending.push_back(make_req(REQ_SHOW, 2'd2, 4'd0, 1'b0));
    req_pending.push_back(make_req(REQ_POINT, 2'd1, 4'd0, 1'b0));
    req_pending.push_back(make_req(REQ_SHOW, 2'd1, 4'd1, 1'b1));
    req_pending.push_back(make_req(REQ_SHOW, 2'd0, 4'd10, 1'b0));
    req_pending.push_back(make_req(REQ_SHOW, 2'd3, 4'd15, 1'b1));
    req_pending.push_back(make_req(REQ_UNUSED, 2'd3, 4'd5, 1'b1));
    req_pending.push_back(make_req(REQ_POINT, 2'd3, 4'd7, 1'b1));
    req_pending.push_back(make_req(REQ_SHOW, 2'd3, 4'd9, 1'b0));
    req_pending.push_back(make_req(REQ_BLANK, 2'd0, 4'd0, 1'b0));

    run_phase(8'd7, 8'd1, 8'd0, 8'hff, 0, 0, 56, 1'b0, 1'b0);
    run_phase(8'd0, 8'd0, 8'd1, 8'h00, 57, 0, 56, 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              0, 57, 56, 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              35, 35, 56, 1'b0, 1'b1);
    run_phase(8'd7, 8'd0, 8'd1, MODE_ADDRESS_RESET, 0, 57, 56, 1'b1, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              0, 0, 56, 1'b0, 1'b0);
    wait_idle();

    $display("Ran %0d display, %0d point and %0d rejected requests under %0d register settings;",
             n_display, n_point, n_rejected, n_settings);
    $display("%0d bus symbols checked, %0d mismatches.", symbols_checked, mismatches);
    if (mismatches == 0 && symbols_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ssdbw_pkg.sv
hdl/ssdbw_front.sv
hdl/ssdbw_queue.sv
hdl/ssdbw_back.sv
hdl/seven_segment_display_bus_writer.sv
test/tb.sv
